// ----- rtl/core/deque_with_search_unit_assert.svh -----
// ---------------------------------------------------------------------------
// deque_with_search_unit_assert
// Assertion macros for the deque RTL.
// Checks are sampled on the rising clock edge and are held off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// Check that the consequent holds whenever the antecedent holds.
`define DWS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds on every clock edge.
`define DWS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ----- rtl/core/dws_pkg.sv -----
// ---------------------------------------------------------------------------
// dws_pkg
// Shared types and constants for the deque with membership search.
// ---------------------------------------------------------------------------
package dws_pkg;

    // Default sizing.
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic clear;
        logic shift_right;
        logic shift_left;
        logic push_back;
        logic pop_back;
    } t_cell_cmd;

endpackage

// ----- rtl/core/deque_with_search_unit.sv -----
// ---------------------------------------------------------------------------
// deque_with_search_unit
// Bounded double-ended queue with push/pop at both ends, membership search
// and clear, built as a chain of storage cells ordered front to back.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | i_op, i_value
//  result  | out       | o_out_valid / i_out_ready  | o_value_out, o_found, o_status,
//          |           |                            | o_count, o_is_empty
//
// Every transaction is handled in one pass: the whole cell chain shifts, loads
// or compares at once, and the result is registered at the same clock edge.
// A new transaction is taken whenever the result register is empty or drains.
// Reset (synchronous, active low) empties the queue; no clearing pass is needed.
// A stalled result holds the input side off until it is taken.
// ---------------------------------------------------------------------------
`include "deque_with_search_unit_assert.svh"

module deque_with_search_unit #(
    parameter int CAPACITY   = dws_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = dws_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dws_pkg::OP_W-1:0]     i_op,
    input  logic signed [dws_pkg::VALUE_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [dws_pkg::VALUE_W-1:0] o_value_out,
    output logic                         o_found,
    output logic [dws_pkg::STATUS_W-1:0] o_status,
    output logic [dws_pkg::COUNT_W-1:0]  o_count,
    output logic                         o_is_empty
);
    import dws_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic                  w_accept;
    logic [DATA_WIDTH-1:0] w_key;
    t_cell_cmd             w_cmd;

    logic [DATA_WIDTH-1:0] w_data  [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_last;
    logic [CAPACITY-1:0]   w_match;
    logic [DATA_WIDTH-1:0] w_tail_data;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  w_full;
    logic                  w_empty;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] n_pop_data;
    logic                  n_found;
    t_status               n_status;
    logic [DATA_WIDTH-1:0] r_pop_data;
    logic                  r_found;
    t_status               r_status;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_is_empty;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_key      = DATA_WIDTH'($unsigned(i_value));
    assign w_full     = (r_count >= FULL_COUNT);
    assign w_empty    = (r_count == '0);

    // Build the cell chain, front at cell 0.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev_data;
        logic                  w_prev_valid;
        logic [DATA_WIDTH-1:0] w_next_data;
        logic                  w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_data  = w_key;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_data  = w_key;
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        dws_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_key       (w_key),
            .i_prev_data (w_prev_data),
            .i_prev_valid(w_prev_valid),
            .i_next_data (w_next_data),
            .i_next_valid(w_next_valid),
            .o_data      (w_data[g]),
            .o_valid     (w_valid[g]),
            .o_last      (w_last[g]),
            .o_match     (w_match[g])
        );
    end

    // Select the tail element: only the last occupied cell passes its data.
    always_comb begin
        w_tail_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_tail_data = w_tail_data | (w_data[k] & {DATA_WIDTH{w_last[k]}});
        end
    end

    // Decode the operation into a chain command and the result fields.
    always_comb begin
        w_cmd      = '0;
        n_count    = r_count;
        n_pop_data = '0;
        n_found    = 1'b0;
        n_status   = ST_OK;
        case (t_op'(i_op))
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.push_back = w_accept;
                    n_count         = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.shift_right = w_accept;
                    n_count           = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.shift_left = w_accept;
                    n_pop_data       = w_data[0];
                    n_count          = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.pop_back = w_accept;
                    n_pop_data     = w_tail_data;
                    n_count        = r_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_found = |w_match;
                end
            end
            OP_CLEAR: begin
                w_cmd.clear = w_accept;
                n_count     = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Advance the element count and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload of an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_data  <= n_pop_data;
            r_found     <= n_found;
            r_status    <= n_status;
            r_out_count <= COUNT_W'(n_count);
            r_is_empty  <= (n_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = VALUE_W'(r_pop_data);
    assign o_found     = r_found;
    assign o_status    = r_status;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_is_empty;

    // Occupied cells always form the count.
    `DWS_ASSERT_ALWAYS(a_count_matches_cells, ($countones(w_valid) == int'(r_count)), "count differs from occupied cells")
    // Occupied cells form one run starting at the front.
    `DWS_ASSERT_ALWAYS(a_valid_prefix, ($onehot0(w_last) && (w_valid[0] || (r_count == '0))), "occupied cells are not a front run")
    // A search hit only ever reports an ok status.
    `DWS_ASSERT_IMPLY(a_found_ok, (r_out_valid && r_found), (r_status == ST_OK), "found reported with a bad status")
    // A rejected push leaves a full queue behind.
    `DWS_ASSERT_IMPLY(a_full_count, (r_out_valid && (r_status == ST_FULL)), (r_count == FULL_COUNT), "full status without a full queue")

endmodule

// ----- rtl/core/dws_cell.sv -----
// ---------------------------------------------------------------------------
// dws_cell
// One storage cell of the deque chain: holds one element and its valid bit,
// trades data with both neighbors and compares itself against the key.
// ---------------------------------------------------------------------------
module dws_cell #(
    parameter int DATA_WIDTH = dws_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dws_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic                  i_prev_valid,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic                  i_next_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_last,
    output logic                  o_match
);
    import dws_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_valid;
    logic                  n_valid;

    // Tail of the occupied run: valid here, empty next door.
    assign o_last  = r_valid & ~i_next_valid;
    assign o_match = r_valid & (r_data == i_key);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    // Pick the next contents from the command and the neighbors.
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.shift_right) begin
            n_valid = i_prev_valid;
            n_data  = i_prev_data;
        end else if (i_cmd.shift_left) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_cmd.push_back && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end else if (i_cmd.pop_back && o_last) begin
            n_valid = 1'b0;
        end
    end

    // Clear the valid bit under reset; data needs none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ----- dv/tb_deque_with_search_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_deque_with_search_unit
// Self-checking bench for the deque with membership search. A short table of
// directed transactions covers the empty, unused-opcode, wrap and clear cases.
// Random fill, drain, mixed and noise phases follow. Each result is compared
// against an in-bench deque model or, for typed rows, the table. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_deque_with_search_unit;
    import dws_pkg::*;

    localparam int          DEPTH        = DEF_CAPACITY;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [2:0]  OP_UNUSED_6  = 3'd6;
    localparam logic [2:0]  OP_UNUSED_7  = 3'd7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic                      found;
        t_status                   status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } t_deque_result;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        t_status            st;
        logic [COUNT_W-1:0] cnt;
    } t_stim_row;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} t_phase;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic [OP_W-1:0]            i_op        = '0;
    logic signed [VALUE_W-1:0]  i_value     = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [VALUE_W-1:0]  o_value_out;
    logic                       o_found;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_count;
    logic                       o_is_empty;

    // Model state: ring of words, head slot and live entry count.
    logic [VALUE_W-1:0] ring_words [DEPTH];
    int                 head_pos   = 0;
    int                 live_count = 0;

    t_deque_result expected_results [$];
    int  error_count   = 0;
    int  cycle_count   = 0;
    int  sent_count    = 0;
    int  result_count  = 0;
    int  burst_left    = 0;
    bit  hold_off_req  = 1'b0;
    int  n_full_reject = 0;
    int  n_empty_hit   = 0;
    int  n_found       = 0;
    int  n_emptied     = 0;
    int  n_clear       = 0;

    // Directed transactions; typed rows carry the result read off directly.
    t_stim_row directed_rows [25] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
        '{OP_SEARCH,     32'h0000_0005, 1'b1, ST_EMPTY, 5'd0},
        '{OP_UNUSED_6,   32'hFFFF_FFFF, 1'b1, ST_OK,    5'd0},
        '{OP_UNUSED_7,   32'h8000_0000, 1'b1, ST_OK,    5'd0},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_OK,    5'd1},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK,    5'd2},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, ST_OK,    5'd0},
        '{OP_SEARCH,     32'h7FFF_FFFF, 1'b0, ST_OK,    5'd0},
        '{OP_SEARCH,     32'h8000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_SEARCH,     32'h0000_0001, 1'b0, ST_OK,    5'd0},
        '{OP_UNUSED_6,   32'h1234_5678, 1'b0, ST_OK,    5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b0, ST_OK,    5'd0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
        '{OP_PUSH_FRONT, 32'h1234_5678, 1'b0, ST_OK,    5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    5'd0},
        '{OP_PUSH_BACK,  32'h55AA_55AA, 1'b0, ST_OK,    5'd0},
        '{OP_PUSH_BACK,  32'hAA55_AA55, 1'b0, ST_OK,    5'd0},
        '{OP_CLEAR,      32'h0000_0000, 1'b1, ST_OK,    5'd0},
        '{OP_SEARCH,     32'h55AA_55AA, 1'b1, ST_EMPTY, 5'd0},
        '{OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, ST_OK,    5'd0}
    };

    deque_with_search_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_out (o_value_out),
        .o_found     (o_found),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    // Generate a 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute the result of one operation and advance the model state.
    task automatic deque_predict(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                                 output t_deque_result r);
        int slot;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (live_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full_reject++;
                end else if (op == OP_PUSH_BACK) begin
                    slot = (head_pos + live_count) % DEPTH;
                    ring_words[slot] = val;
                    live_count++;
                end else begin
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                    ring_words[head_pos] = val;
                    live_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_SEARCH: begin
                if (live_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_hit++;
                end else if (op == OP_POP_FRONT) begin
                    r.value_out = ring_words[head_pos];
                    head_pos = (head_pos + 1) % DEPTH;
                    live_count--;
                    if (live_count == 0) n_emptied++;
                end else if (op == OP_POP_BACK) begin
                    r.value_out = ring_words[(head_pos + live_count - 1) % DEPTH];
                    live_count--;
                    if (live_count == 0) n_emptied++;
                end else begin
                    for (int i = 0; i < live_count; i++) begin
                        if (ring_words[(head_pos + i) % DEPTH] == val) r.found = 1'b1;
                    end
                    if (r.found) n_found++;
                end
            end
            OP_CLEAR: begin
                live_count = 0;
                head_pos = 0;
                n_clear++;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(live_count);
        r.is_empty = (live_count == 0);
    endtask

    // Offer one transaction, hold it until taken, then record its expected result.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input bit typed, input t_deque_result typed_exp);
        t_deque_result pred;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        deque_predict(op, val, pred);
        expected_results.push_back(typed ? typed_exp : pred);
        sent_count++;
    endtask

    // Count down the current burst; at its end maybe drop valid for a random gap.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'h7FFF_FFFF;
        if (r < 16) return 32'h8000_0000;
        if (r < 20) return 32'h0000_0000;
        if (r < 24) return 32'hFFFF_FFFF;
        if (r < 45) return VALUE_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    // Search mostly for something stored, otherwise for any value.
    function automatic logic [VALUE_W-1:0] pick_search_value();
        if (live_count > 0 && $urandom_range(0, 9) < 6)
            return ring_words[(head_pos + $urandom_range(0, live_count - 1)) % DEPTH];
        return pick_value();
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 40) return OP_PUSH_BACK;
                if (r < 80) return OP_PUSH_FRONT;
                if (r < 88) return OP_SEARCH;
                if (r < 94) return OP_POP_FRONT;
                return OP_POP_BACK;
            end
            PH_DRAIN: begin
                if (r < 35) return OP_POP_FRONT;
                if (r < 70) return OP_POP_BACK;
                if (r < 85) return OP_SEARCH;
                if (r < 95) return OP_PUSH_BACK;
                return OP_PUSH_FRONT;
            end
            PH_MIX: begin
                if (r < 20) return OP_PUSH_BACK;
                if (r < 40) return OP_PUSH_FRONT;
                if (r < 58) return OP_POP_FRONT;
                if (r < 76) return OP_POP_BACK;
                if (r < 97) return OP_SEARCH;
                return OP_CLEAR;
            end
            default: begin
                if (r < 30) return OP_UNUSED_6;
                if (r < 60) return OP_UNUSED_7;
                if (r < 75) return OP_CLEAR;
                if (r < 87) return OP_POP_FRONT;
                return OP_SEARCH;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 50)
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     result_count, what, got, want);
        error_count++;
    endtask

    // Check each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_value_out !== want.value_out)
                    report_mismatch("value_out", o_value_out, want.value_out);
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_count !== want.count)
                    report_mismatch("count", o_count, want.count);
                if (o_is_empty !== want.is_empty)
                    report_mismatch("is_empty", o_is_empty, want.is_empty);
            end
            result_count++;
        end
    end

    // Stall the result side on a changing pattern; hold off once for a long stretch.
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ((mode_left % 12) < 4);
                endcase
            end
        end
    end

    // Bound the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("[deque_with_search_unit] ERROR");
            $finish;
        end
    end

    // Reset, walk the directed table, then run the random phases.
    initial begin
        t_deque_result  typed_exp;
        t_phase         phase;
        int             phase_left;
        int             counted;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            typed_exp = '0;
            typed_exp.status   = directed_rows[k].st;
            typed_exp.count    = directed_rows[k].cnt;
            typed_exp.is_empty = (directed_rows[k].cnt == 0);
            send_item(directed_rows[k].op, directed_rows[k].value,
                      directed_rows[k].typed, typed_exp);
            pace_sender();
        end

        hold_off_req = 1'b1;
        phase = PH_FILL;
        phase_left = 0;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase = t_phase'($urandom_range(0, 9) < 4 ? PH_FILL :
                                 $urandom_range(0, 5) < 3 ? PH_DRAIN :
                                 $urandom_range(0, 4) < 4 ? PH_MIX : PH_NOISE);
                phase_left = $urandom_range(5, 40);
            end
            op  = pick_op(phase);
            val = (op == OP_SEARCH) ? pick_search_value() : pick_value();
            send_item(op, val, 1'b0, '0);
            if (op <= OP_CLEAR) counted++;
            phase_left--;
            pace_sender();
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("ran %0d transactions, %0d results checked, %0d mismatches",
                 sent_count, result_count, error_count);
        $display("full rejects %0d, empty pop/search %0d, search hits %0d, %s %0d, clears %0d",
                 n_full_reject, n_empty_hit, n_found, "emptied by pop", n_emptied, n_clear);
        if (error_count == 0) begin
            $display("[deque_with_search_unit] OK");
        end else begin
            $display("[deque_with_search_unit] ERROR");
        end
        $finish;
    end

endmodule
